// File: hw/rtl/wrf_pkg.sv
// Shared constants and types for the windowed region finder.
`default_nettype none

package wrf_pkg;

  localparam int MAX_LOOKAHEAD_DEF = 64;
  localparam int INDEX_BITS_DEF    = 24;

  localparam int CFG_W   = 7;
  localparam int LABEL_W = 2;
  localparam int OUT_W   = 24;
  localparam int COUNT_W = 7;
  localparam int SCORE_W = 24;

  localparam logic [CFG_W-1:0]   CFG_DEPTH_RESET = 7'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 7'd127;
  localparam logic [SCORE_W-1:0] SCORE_MAX       = 24'hFFFFFF;

  localparam logic [LABEL_W-1:0] LABEL_QUIET  = 2'd0;
  localparam logic [LABEL_W-1:0] LABEL_ACTIVE = 2'd1;
  localparam logic [LABEL_W-1:0] LABEL_END    = 2'd2;
  localparam logic [LABEL_W-1:0] LABEL_RSVD   = 2'd3;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef count_t [2:0]       counts_t;

endpackage

`default_nettype wire

// File: hw/rtl/windowed_region_finder.sv
// Top level of the windowed region finder: label window, counts, region tracker.
`default_nettype none

// One label beat is taken per clock, back to back, with no gap between streams. Each beat's
// whole update (window counts, rate tests, region state machine) is combinational between
// the input handshake and the state and result registers; the label window is a circular
// buffer held in two copies of a 2-bit memory whose reads are registered from the next
// pointer and depth, ready when their beat is taken. The result of a stream appears on
// the output the cycle after its last beat. The input stalls only when a last beat arrives
// while the previous result is still held by a stalled output; other beats keep flowing.
module windowed_region_finder #(
  parameter int MAX_LOOKAHEAD = wrf_pkg::MAX_LOOKAHEAD_DEF,
  parameter int INDEX_BITS    = wrf_pkg::INDEX_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire  [wrf_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [wrf_pkg::LABEL_W-1:0]    in_label,
  input  wire                            in_last,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [wrf_pkg::OUT_W-1:0]      out_region_start,
  output logic [wrf_pkg::OUT_W-1:0]      out_region_end
);
  import wrf_pkg::*;

  localparam int LW    = $clog2(MAX_LOOKAHEAD + 1);
  localparam int PW    = $clog2(2 * MAX_LOOKAHEAD + 3);
  localparam int DEPTH = 1 << PW;
  localparam int IW    = INDEX_BITS;
  localparam int CW    = (IW > LW + 2) ? IW + 1 : LW + 3;
  localparam int SW    = COUNT_W + LW + 3;
  localparam int XW    = COUNT_W + 2 * LW + 6;

  typedef enum logic {ST_CLOSED, ST_OPEN} region_state_t;

  function automatic logic [LW-1:0] depth_clamp(input logic [CFG_W-1:0] v);
    logic [LW-1:0] r;
    if (v == '0) r = LW'(1);
    else if (32'(v) > MAX_LOOKAHEAD) r = LW'(MAX_LOOKAHEAD);
    else r = LW'(v);
    return r;
  endfunction

  function automatic counts_t cnt_up(input counts_t c, input label_t lab);
    counts_t r;
    r = c;
    case (lab)
      LABEL_QUIET, LABEL_ACTIVE, LABEL_END: begin
        if (c[lab] != COUNT_MAX) r[lab] = c[lab] + COUNT_W'(1);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic counts_t cnt_down(input counts_t c, input label_t lab);
    counts_t r;
    r = c;
    case (lab)
      LABEL_QUIET, LABEL_ACTIVE, LABEL_END: begin
        if (c[lab] != '0) r[lab] = c[lab] - COUNT_W'(1);
      end
      default: ;
    endcase
    return r;
  endfunction

  logic [CFG_W-1:0]   cfg_depth_r;
  logic [PW-1:0]      wptr_r, wptr_nxt;
  logic [IW-1:0]      block_index_r, block_index_nxt;
  counts_t            look_cnt_r, look_cnt_nxt;
  counts_t            hist_cnt_r, hist_cnt_nxt;
  region_state_t      state_r, state_nxt;
  logic [IW-1:0]      open_start_r, open_start_nxt;
  logic [SCORE_W-1:0] open_score_r, open_score_nxt;
  logic [IW-1:0]      best_start_r, best_start_nxt;
  logic [IW-1:0]      best_end_r, best_end_nxt;
  logic [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_start_r, out_start_nxt;
  logic [OUT_W-1:0]   out_end_r, out_end_nxt;

  label_t win_a_mem [DEPTH];
  label_t win_c_mem [DEPTH];
  label_t rd_a_r, rd_b_r, rd_c_r, byp_lab_r;
  logic   hit_a_r;

  logic          in_acc;
  label_t        in_lab, dec_lab;
  logic [LW-1:0] l_cur, l_nxt, h_cur;
  logic [PW-1:0] l_ptr, addr_a, addr_b, addr_c;
  logic [CW-1:0] t_ext, l_ext, diff;
  logic          decide, has_hist, drop_old;
  logic [IW-1:0] d_idx, bidx_sat;
  counts_t       look_v, hist_v;
  logic [COUNT_W-1:0] a1, a2, b2;
  logic          rate1_ok, rate2_ok, sum_ok, open_ok;
  logic [XW-1:0] lhs_sum, rhs_sum;

  region_state_t      state_v;
  logic [IW-1:0]      start_v, bstart_v, bend_v;
  logic [SCORE_W-1:0] score_v, bscore_v;

  assign in_stall  = out_valid_r & out_stall & in_last;
  assign in_acc    = in_valid & ~in_stall;
  assign in_lab    = (in_label == LABEL_RSVD) ? LABEL_QUIET : in_label;
  assign out_valid = out_valid_r;
  assign out_region_start = out_start_r;
  assign out_region_end   = out_end_r;

  // read addresses are formed from next-cycle pointer and depth
  assign l_cur    = depth_clamp(cfg_depth_r);
  assign l_nxt    = !rst_n ? depth_clamp(CFG_DEPTH_RESET)
                  : (cfg_we ? depth_clamp(cfg_wdata) : l_cur);
  assign wptr_nxt = !rst_n ? '0 : (in_acc ? wptr_r + PW'(1) : wptr_r);
  assign l_ptr    = PW'(l_nxt);
  assign addr_a   = wptr_nxt - l_ptr;
  assign addr_b   = addr_a - PW'(1);
  assign addr_c   = wptr_nxt - (l_ptr << 1) - PW'(1);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_a_mem[wptr_r] <= in_lab;
      win_c_mem[wptr_r] <= in_lab;
    end
    rd_a_r    <= win_a_mem[addr_a];
    rd_b_r    <= win_a_mem[addr_b];
    rd_c_r    <= win_c_mem[addr_c];
    hit_a_r   <= in_acc && (addr_a == wptr_r);
    byp_lab_r <= in_lab;
  end

  assign dec_lab  = hit_a_r ? byp_lab_r : rd_a_r;
  assign t_ext    = CW'(block_index_r);
  assign l_ext    = CW'(l_cur);
  assign drop_old = t_ext >= ((l_ext << 1) + CW'(1));
  assign decide   = t_ext >= l_ext;
  assign has_hist = t_ext > l_ext;
  assign diff     = t_ext - l_ext;
  assign d_idx    = IW'(diff);
  assign h_cur    = (diff < l_ext) ? LW'(diff) : l_cur;
  assign bidx_sat = (block_index_r == '1) ? block_index_r : block_index_r + IW'(1);

  always_comb begin
    hist_v = hist_cnt_r;
    look_v = look_cnt_r;
    if (drop_old) hist_v = cnt_down(hist_v, rd_c_r);
    look_v = cnt_up(look_v, in_lab);
    if (decide) begin
      if (has_hist) hist_v = cnt_up(hist_v, rd_b_r);
      look_v = cnt_down(look_v, dec_lab);
    end
  end

  assign a1       = look_v[LABEL_ACTIVE];
  assign a2       = look_v[LABEL_END];
  assign b2       = has_hist ? hist_v[LABEL_END] : '0;
  assign rate1_ok = SW'(a1) * SW'(5) >= SW'(l_cur) * SW'(2);
  assign rate2_ok = SW'(a2) * SW'(5) >= SW'(l_cur) * SW'(2);
  assign lhs_sum  = has_hist ? XW'(10) * (XW'(a2) * XW'(h_cur) + XW'(b2) * XW'(l_cur))
                             : XW'(10) * XW'(a2);
  assign rhs_sum  = has_hist ? XW'(9) * (XW'(l_cur) * XW'(h_cur)) : XW'(9) * XW'(l_cur);
  assign sum_ok   = lhs_sum >= rhs_sum;
  assign open_ok  = (dec_lab == LABEL_ACTIVE) && rate1_ok && (a2 == '0) && (b2 == '0);

  always_comb begin
    state_v  = state_r;
    start_v  = open_start_r;
    score_v  = open_score_r;
    bstart_v = best_start_r;
    bend_v   = best_end_r;
    bscore_v = best_score_r;
    if (decide) begin
      unique case (state_r)
        ST_OPEN: begin
          if (dec_lab == LABEL_ACTIVE && score_v != SCORE_MAX) score_v = score_v + SCORE_W'(1);
          if (dec_lab == LABEL_END && rate2_ok && sum_ok) begin
            if (score_v > bscore_v) begin
              bscore_v = score_v;
              bstart_v = start_v;
              bend_v   = d_idx;
            end
            state_v = ST_CLOSED;
          end
        end
        ST_CLOSED: begin
          if (open_ok) begin
            state_v = ST_OPEN;
            start_v = d_idx;
            score_v = SCORE_W'(1);
          end
        end
        default: ;
      endcase
    end
    // stream end: an open region closes at the block count
    if (in_last && state_v == ST_OPEN && score_v > bscore_v) begin
      bscore_v = score_v;
      bstart_v = start_v;
      bend_v   = bidx_sat;
    end
  end

  always_comb begin
    block_index_nxt = block_index_r;
    look_cnt_nxt    = look_cnt_r;
    hist_cnt_nxt    = hist_cnt_r;
    state_nxt       = state_r;
    open_start_nxt  = open_start_r;
    open_score_nxt  = open_score_r;
    best_start_nxt  = best_start_r;
    best_end_nxt    = best_end_r;
    best_score_nxt  = best_score_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_start_nxt   = out_start_r;
    out_end_nxt     = out_end_r;
    if (in_acc) begin
      if (in_last) begin
        block_index_nxt = '0;
        look_cnt_nxt    = '0;
        hist_cnt_nxt    = '0;
        state_nxt       = ST_CLOSED;
        open_start_nxt  = '0;
        open_score_nxt  = '0;
        best_start_nxt  = '0;
        best_end_nxt    = '0;
        best_score_nxt  = '0;
        out_valid_nxt   = 1'b1;
        out_start_nxt   = OUT_W'(bstart_v);
        out_end_nxt     = OUT_W'(bend_v);
      end else begin
        block_index_nxt = bidx_sat;
        look_cnt_nxt    = look_v;
        hist_cnt_nxt    = hist_v;
        state_nxt       = state_v;
        open_start_nxt  = start_v;
        open_score_nxt  = score_v;
        best_start_nxt  = bstart_v;
        best_end_nxt    = bend_v;
        best_score_nxt  = bscore_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_depth_r   <= CFG_DEPTH_RESET;
      wptr_r        <= '0;
      block_index_r <= '0;
      look_cnt_r    <= '0;
      hist_cnt_r    <= '0;
      state_r       <= ST_CLOSED;
      open_start_r  <= '0;
      open_score_r  <= '0;
      best_start_r  <= '0;
      best_end_r    <= '0;
      best_score_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) cfg_depth_r <= cfg_wdata;
      wptr_r        <= wptr_nxt;
      block_index_r <= block_index_nxt;
      look_cnt_r    <= look_cnt_nxt;
      hist_cnt_r    <= hist_cnt_nxt;
      state_r       <= state_nxt;
      open_start_r  <= open_start_nxt;
      open_score_r  <= open_score_nxt;
      best_start_r  <= best_start_nxt;
      best_end_r    <= best_end_nxt;
      best_score_r  <= best_score_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (out_valid && block_index_r == '0 && state_r == ST_CLOSED))
    else $error("last beat did not produce a result and clear the stream state");

  a_open_scored: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OPEN) |-> (open_score_r != '0))
    else $error("open region with zero score");

  a_best_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (best_score_r == '0) |-> (best_start_r == '0 && best_end_r == '0))
    else $error("best region bounds set without a score");
`endif

endmodule

`default_nettype wire

// File: verif/windowed_region_finder_tb.sv
// Testbench for windowed_region_finder: label streams checked against an in-bench region tracker.
`timescale 1ns / 1ps

module windowed_region_finder_tb;
  import wrf_pkg::*;

  localparam int          MAX_LA      = MAX_LOOKAHEAD_DEF;
  localparam int          WIN_LEN     = 2 * MAX_LA + 1;
  localparam int unsigned IDX_MAX     = (1 << INDEX_BITS_DEF) - 1;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    label_t lab;
    logic   fin;
  } beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] start_idx;
    logic [OUT_W-1:0] stop_idx;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  label_t in_label = LABEL_QUIET;
  logic in_last = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [OUT_W-1:0] out_region_start;
  logic [OUT_W-1:0] out_region_end;

  windowed_region_finder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_label         (in_label),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_region_start (out_region_start),
    .out_region_end   (out_region_end)
  );

  // region tracker state
  logic [CFG_W-1:0] depth_reg = CFG_DEPTH_RESET;
  label_t      win [0:WIN_LEN-1];
  int unsigned la_cnt [0:2];
  int unsigned hs_cnt [0:2];
  int unsigned blk_idx;
  logic        open_flag;
  int unsigned open_start, open_score;
  int unsigned best_start, best_stop, best_score;

  span_t wanted_spans[$];
  beat_t pend_beats[$];

  logic        beat_taken = 1'b0;
  int unsigned beats_seen = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  int unsigned stim_items = 0;
  int unsigned stim_streams = 0;
  int unsigned depth_writes = 0;
  int unsigned stim_lk = 32'(CFG_DEPTH_RESET);

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned run_left = 0;
  logic        run_on = 1'b0;

  function automatic int unsigned cnt_up(input int unsigned c);
    return (c >= COUNT_MAX) ? c : c + 1;
  endfunction

  function automatic int unsigned cnt_down(input int unsigned c);
    return (c == 0) ? 0 : c - 1;
  endfunction

  task automatic clear_track();
    for (int i = 0; i < WIN_LEN; i++) win[i] = LABEL_QUIET;
    for (int i = 0; i < 3; i++) begin
      la_cnt[i] = 0;
      hs_cnt[i] = 0;
    end
    blk_idx = 0;
    open_flag = 1'b0;
    open_start = 0;
    open_score = 0;
    best_start = 0;
    best_stop = 0;
    best_score = 0;
  endtask

  task automatic close_span(input int unsigned stop);
    if (open_score > best_score) begin
      best_score = open_score;
      best_start = open_start;
      best_stop = stop;
    end
    open_flag = 1'b0;
  endtask

  task automatic judge_block(input label_t lab_in, input logic fin);
    int unsigned lk, t, h, dec_idx;
    label_t lab, dec;
    longint unsigned a1, a2, b2;
    logic sum_ok;
    span_t s;
    lab = (lab_in == LABEL_RSVD) ? LABEL_QUIET : lab_in;
    lk = 32'(depth_reg);
    if (lk < 1) lk = 1;
    if (lk > MAX_LA) lk = MAX_LA;
    t = blk_idx;
    if (t >= 2 * lk + 1) hs_cnt[win[2*lk]] = cnt_down(hs_cnt[win[2*lk]]);
    for (int i = WIN_LEN - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = lab;
    la_cnt[lab] = cnt_up(la_cnt[lab]);
    if (t >= lk) begin
      dec = win[lk];
      dec_idx = t - lk;
      if (t >= lk + 1) hs_cnt[win[lk+1]] = cnt_up(hs_cnt[win[lk+1]]);
      la_cnt[dec] = cnt_down(la_cnt[dec]);
      h = (t - lk < lk) ? t - lk : lk;
      a1 = 64'(la_cnt[LABEL_ACTIVE]);
      a2 = 64'(la_cnt[LABEL_END]);
      b2 = (h > 0) ? 64'(hs_cnt[LABEL_END]) : 64'(0);
      if (open_flag) begin
        if (dec == LABEL_ACTIVE)
          open_score = (open_score >= SCORE_MAX) ? 32'(SCORE_MAX) : open_score + 1;
        if (dec == LABEL_END && 5 * a2 >= 2 * lk) begin
          if (h > 0) sum_ok = 10 * (a2 * h + b2 * lk) >= 9 * lk * h;
          else sum_ok = 10 * a2 >= 9 * lk;
          if (sum_ok) close_span(dec_idx);
        end
      end else if (dec == LABEL_ACTIVE && 5 * a1 >= 2 * lk && a2 == 0 && b2 == 0) begin
        open_flag = 1'b1;
        open_start = dec_idx;
        open_score = 1;
      end
    end
    blk_idx = (t >= IDX_MAX) ? IDX_MAX : t + 1;
    if (fin) begin
      if (open_flag) close_span(blk_idx);
      s.start_idx = best_start[OUT_W-1:0];
      s.stop_idx = best_stop[OUT_W-1:0];
      wanted_spans = {wanted_spans, s};
      clear_track();
    end
  endtask

  task automatic flag_bad(input string what, input logic [OUT_W-1:0] want,
                          input logic [OUT_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // monitor: input beats feed the tracker, result beats are checked
  always @(posedge clk) begin : watch_blk
    span_t s;
    if (!rst_n) begin
      clear_track();
      depth_reg = CFG_DEPTH_RESET;
      beat_taken = 1'b0;
    end else begin
      if (cfg_we) depth_reg = cfg_wdata;
      beat_taken = in_valid && !in_stall;
      if (beat_taken) begin
        judge_block(in_label, in_last);
        beats_seen++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (wanted_spans.size() == 0) begin
          flag_bad("result with none pending", '0, out_region_start);
        end else begin
          s = wanted_spans.pop_front();
          if (out_region_start !== s.start_idx) flag_bad("region_start", s.start_idx, out_region_start);
          if (out_region_end !== s.stop_idx) flag_bad("region_end", s.stop_idx, out_region_end);
        end
      end
    end
  end

  // sender: bursts of beats with random gaps
  always @(negedge clk) begin : drive_blk
    beat_t b;
    logic nv, nf;
    label_t nl;
    nv = in_valid;
    nl = in_label;
    nf = in_last;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || beat_taken) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_beats.size() > 0) begin
        b = pend_beats.pop_front();
        nv = 1'b1;
        nl = b.lab;
        nf = b.fin;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = 1;
            2: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 12);
          endcase
        end
      end
    end
    in_valid <= nv;
    in_label <= nl;
    in_last <= nf;
  end

  // receiver: stall pattern switches between modes
  always @(negedge clk) begin : stall_blk
    logic ns;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: ns = 1'b0;
      1: ns = 1'($urandom_range(0, 1));
      2: begin
        if (run_left == 0) begin
          run_on = !run_on;
          run_left = run_on ? $urandom_range(1, 20) : $urandom_range(1, 6);
        end else begin
          run_left--;
        end
        ns = run_on;
      end
      default: ns = ($urandom_range(0, 7) == 0);
    endcase
    if (!rst_n) ns = 1'b0;
    out_stall <= ns;
  end

  task automatic drain_wait();
    @(negedge clk);
    while (beats_seen != stim_items || wanted_spans.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_depth(input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    stim_lk = (v < 1) ? 1 : (v > MAX_LA) ? MAX_LA : 32'(v);
    depth_writes++;
  endtask

  task automatic queue_labels(input label_t labs[$], input int from, input int upto,
                              input logic close);
    beat_t b;
    for (int i = from; i < upto; i++) begin
      b.lab = labs[i];
      b.fin = close && (i == upto - 1);
      pend_beats = {pend_beats, b};
      stim_items++;
    end
  endtask

  task automatic add_run(ref label_t labs[$], input label_t lab, input int unsigned n);
    repeat (n)
      labs = {labs, (($urandom_range(0, 15) == 0) ? label_t'($urandom_range(0, 3)) : lab)};
  endtask

  task automatic queue_stream();
    label_t labs[$];
    int unsigned lk, reps, cut;
    lk = stim_lk;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3 * lk + 2)) labs = {labs, label_t'($urandom_range(0, 3))};
    end else begin
      reps = (lk > 16) ? 1 : $urandom_range(1, 3);
      repeat (reps) begin
        add_run(labs, LABEL_QUIET, $urandom_range(0, lk));
        add_run(labs, LABEL_ACTIVE, $urandom_range(1, 2 * lk + 1));
        add_run(labs, LABEL_END, $urandom_range(1, 2 * lk + 1));
      end
      add_run(labs, LABEL_QUIET, $urandom_range(0, lk + 1));
      // broken sequence: cut short
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, labs.size());
        while (labs.size() > cut) void'(labs.pop_back());
      end
    end
    // depth shrinks mid-stream
    if (lk > 1 && labs.size() > 1 && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, labs.size() - 1);
      queue_labels(labs, 0, cut, 1'b0);
      drain_wait();
      write_depth(CFG_W'($urandom_range(1, lk - 1)));
      queue_labels(labs, cut, labs.size(), 1'b1);
    end else begin
      queue_labels(labs, 0, labs.size(), 1'b1);
    end
    stim_streams++;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] v);
    int unsigned phase_start;
    drain_wait();
    write_depth(v);
    phase_start = stim_items;
    do queue_stream(); while (stim_items - phase_start < 64);
  endtask

  initial begin : stim_blk
    label_t labs[$];
    logic [CFG_W-1:0] depth_plan [12];
    depth_plan = '{7'd1, 7'd0, 7'd3, 7'd127, 7'd8, 7'd2, 7'd64, 7'd5, 7'd65, 7'd4, 7'd16, 7'd6};
    wait (rst_n === 1'b1);
    @(negedge clk);

    // reset depth, reserved label alone
    labs = '{LABEL_RSVD};
    queue_labels(labs, 0, labs.size(), 1'b1);
    stim_streams++;
    drain_wait();
    write_depth(7'd2);
    labs = '{LABEL_QUIET, LABEL_ACTIVE, LABEL_ACTIVE, LABEL_ACTIVE, LABEL_END, LABEL_END,
             LABEL_END, LABEL_END, LABEL_RSVD};
    queue_labels(labs, 0, labs.size(), 1'b1);
    labs = '{LABEL_END};
    queue_labels(labs, 0, labs.size(), 1'b1);
    // region still open at the last beat
    labs = '{LABEL_ACTIVE, LABEL_ACTIVE, LABEL_ACTIVE, LABEL_ACTIVE, LABEL_ACTIVE};
    queue_labels(labs, 0, labs.size(), 1'b1);
    // two regions with equal score
    labs = '{LABEL_ACTIVE, LABEL_ACTIVE, LABEL_END, LABEL_END, LABEL_END,
             LABEL_ACTIVE, LABEL_ACTIVE, LABEL_END, LABEL_END, LABEL_END};
    queue_labels(labs, 0, labs.size(), 1'b1);
    stim_streams += 4;

    foreach (depth_plan[p]) run_phase(depth_plan[p]);
    while (stim_items < 1250 || stim_streams < 48) run_phase(CFG_W'($urandom_range(1, 12)));

    drain_wait();
    repeat (16) @(negedge clk);
    $display("covered %0d beats in %0d streams over %0d depth settings",
             beats_seen, stim_streams, depth_writes);
    $display("checked %0d region results, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wrf_pkg.sv
hw/rtl/windowed_region_finder.sv
verif/windowed_region_finder_tb.sv
